[rtl/core/pida_pkg.sv]
// Shared types and constants of the process ID allocator.
package pida_pkg;

    localparam int SLOTS  = 64;
    localparam int ID_W   = 6;
    localparam int LINK_W = 7;
    localparam int CNT_W  = 7;

    localparam logic [LINK_W-1:0] NIL_LINK = 7'd64;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_LIST  = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_OUT_OF_IDS  = 2'd1;
    localparam logic [1:0] ST_NOT_RUNNING = 2'd2;

    typedef struct packed {
        logic              nl_we;
        logic [ID_W-1:0]   nl_waddr;
        logic [LINK_W-1:0] nl_wdata;
        logic              pl_we;
        logic [ID_W-1:0]   pl_waddr;
        logic [LINK_W-1:0] pl_wdata;
        logic              rd_en;
        logic [ID_W-1:0]   raddr;
    } t_link_req;

endpackage

[rtl/core/pida_links.sv]
// Next and previous link memories of the running list, with registered read data.
module pida_links (
    input  logic                           i_clk,
    input  pida_pkg::t_link_req            i_req,
    output logic [pida_pkg::LINK_W-1:0]    o_next_q,
    output logic [pida_pkg::LINK_W-1:0]    o_prev_q
);

    logic [pida_pkg::LINK_W-1:0] r_next_mem [pida_pkg::SLOTS];
    logic [pida_pkg::LINK_W-1:0] r_prev_mem [pida_pkg::SLOTS];
    logic [pida_pkg::LINK_W-1:0] r_next_q;
    logic [pida_pkg::LINK_W-1:0] r_prev_q;

    always_ff @(posedge i_clk) begin
        if (i_req.nl_we) begin
            r_next_mem[i_req.nl_waddr] <= i_req.nl_wdata;
        end
        if (i_req.rd_en) begin
            r_next_q <= r_next_mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.pl_we) begin
            r_prev_mem[i_req.pl_waddr] <= i_req.pl_wdata;
        end
        if (i_req.rd_en) begin
            r_prev_q <= r_prev_mem[i_req.raddr];
        end
    end

    assign o_next_q = r_next_q;
    assign o_prev_q = r_prev_q;

endmodule

[rtl/core/process_id_allocator_top.sv]
// Process ID allocator: free stack, fresh counter and doubly linked running list.
//
// One command beat at a time. Allocate steps through stack or counter, head link,
// back link and response; a valid free through link read, unlink and response;
// a rejected free or out-of-ids allocate only through response. A list gives
// one beat per running ID, or a lone beat if none runs, paced by the one read
// a cycle of the next-link memory while the output is not stalled. The next
// command is taken as soon as the sequencer is back at idle, while the last
// result beat may still wait in the output register. Running flags clear at
// reset; the free stack and link memories need no clearing pass, as no entry
// is read before it is written. IDs at or above ID_LIMIT are never handed out.
module process_id_allocator_top #(
    parameter int ID_LIMIT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_pid,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_id_out,
    output logic [6:0]  o_running_total,
    output logic        o_last
);

    localparam logic [pida_pkg::CNT_W-1:0] LIMIT_C = pida_pkg::CNT_W'(ID_LIMIT);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_AL_LINK   = 3'd1;
    localparam logic [2:0] S_AL_BACK   = 3'd2;
    localparam logic [2:0] S_FR_UNLINK = 3'd3;
    localparam logic [2:0] S_LIST      = 3'd4;
    localparam logic [2:0] S_RESP      = 3'd5;

    logic [2:0]                        r_state, n_state;
    logic [pida_pkg::CNT_W-1:0]        r_fresh, n_fresh;
    logic [pida_pkg::CNT_W-1:0]        r_fdepth, n_fdepth;
    logic [pida_pkg::CNT_W-1:0]        r_count, n_count;
    logic [pida_pkg::LINK_W-1:0]       r_head, n_head;
    logic [pida_pkg::SLOTS-1:0]        r_running, n_running;
    logic [pida_pkg::ID_W-1:0]         r_rid, n_rid;
    logic [1:0]                        r_status, n_status;
    logic                              r_pop, n_pop;
    logic [pida_pkg::CNT_W-1:0]        r_k, n_k;

    logic                              r_out_valid;
    logic [1:0]                        r_o_status;
    logic [5:0]                        r_o_id;
    logic [6:0]                        r_o_total;
    logic                              r_o_last;

    logic                              out_free;
    logic                              out_load;
    logic [1:0]                        out_status;
    logic [5:0]                        out_id;
    logic                              out_last;

    logic [pida_pkg::ID_W-1:0]         r_fstack [pida_pkg::SLOTS];
    logic [pida_pkg::ID_W-1:0]         r_fs_q;
    logic                              fs_we;
    logic [pida_pkg::ID_W-1:0]         fs_waddr;
    logic [pida_pkg::ID_W-1:0]         fs_wdata;
    logic                              fs_re;
    logic [pida_pkg::ID_W-1:0]         fs_raddr;

    pida_pkg::t_link_req               link_req;
    logic [pida_pkg::LINK_W-1:0]       next_q;
    logic [pida_pkg::LINK_W-1:0]       prev_q;

    logic [pida_pkg::CNT_W-1:0]        fdepth_m1;
    logic [pida_pkg::CNT_W-1:0]        k_p1;
    logic [pida_pkg::ID_W-1:0]         al_id;
    logic                              pid_ok;
    logic                              list_fin;

    pida_links u_links (
        .i_clk    (i_clk),
        .i_req    (link_req),
        .o_next_q (next_q),
        .o_prev_q (prev_q)
    );

    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            r_fstack[fs_waddr] <= fs_wdata;
        end
        if (fs_re) begin
            r_fs_q <= r_fstack[fs_raddr];
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign fdepth_m1  = r_fdepth - 7'd1;
    assign k_p1       = r_k + 7'd1;
    assign al_id      = r_pop ? r_fs_q : r_rid;
    assign pid_ok     = ({1'b0, i_pid} < LIMIT_C);
    assign list_fin   = next_q[pida_pkg::LINK_W-1] || (k_p1 >= r_count);

    always_comb begin
        n_state    = r_state;
        n_fresh    = r_fresh;
        n_fdepth   = r_fdepth;
        n_count    = r_count;
        n_head     = r_head;
        n_running  = r_running;
        n_rid      = r_rid;
        n_status   = r_status;
        n_pop      = r_pop;
        n_k        = r_k;
        link_req   = '0;
        fs_we      = 1'b0;
        fs_waddr   = r_fdepth[pida_pkg::ID_W-1:0];
        fs_wdata   = r_rid;
        fs_re      = 1'b0;
        fs_raddr   = fdepth_m1[pida_pkg::ID_W-1:0];
        out_load   = 1'b0;
        out_status = r_status;
        out_id     = r_rid;
        out_last   = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_operation)
                        pida_pkg::OP_ALLOC: begin
                            if (r_fdepth != '0) begin
                                fs_re    = 1'b1;
                                n_fdepth = fdepth_m1;
                                n_pop    = 1'b1;
                                n_state  = S_AL_LINK;
                            end else if (r_fresh < LIMIT_C) begin
                                n_rid   = r_fresh[pida_pkg::ID_W-1:0];
                                n_fresh = r_fresh + 7'd1;
                                n_pop   = 1'b0;
                                n_state = S_AL_LINK;
                            end else begin
                                n_status = pida_pkg::ST_OUT_OF_IDS;
                                n_rid    = '0;
                                n_state  = S_RESP;
                            end
                        end
                        pida_pkg::OP_FREE: begin
                            if (pid_ok && r_running[i_pid]) begin
                                link_req.rd_en = 1'b1;
                                link_req.raddr = i_pid;
                                n_rid          = i_pid;
                                n_state        = S_FR_UNLINK;
                            end else begin
                                n_status = pida_pkg::ST_NOT_RUNNING;
                                n_rid    = '0;
                                n_state  = S_RESP;
                            end
                        end
                        pida_pkg::OP_LIST: begin
                            if (r_count == '0) begin
                                n_status = pida_pkg::ST_OK;
                                n_rid    = '0;
                                n_state  = S_RESP;
                            end else begin
                                link_req.rd_en = 1'b1;
                                link_req.raddr = r_head[pida_pkg::ID_W-1:0];
                                n_rid          = r_head[pida_pkg::ID_W-1:0];
                                n_k            = '0;
                                n_status       = pida_pkg::ST_OK;
                                n_state        = S_LIST;
                            end
                        end
                        default: begin
                            n_status = pida_pkg::ST_OK;
                            n_rid    = '0;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end
            S_AL_LINK: begin
                link_req.nl_we    = 1'b1;
                link_req.nl_waddr = al_id;
                link_req.nl_wdata = r_head;
                if (!r_head[pida_pkg::LINK_W-1]) begin
                    link_req.pl_we    = 1'b1;
                    link_req.pl_waddr = r_head[pida_pkg::ID_W-1:0];
                    link_req.pl_wdata = {1'b0, al_id};
                end
                n_head           = {1'b0, al_id};
                n_running[al_id] = 1'b1;
                n_count          = r_count + 7'd1;
                n_rid            = al_id;
                n_status         = pida_pkg::ST_OK;
                n_state          = S_AL_BACK;
            end
            S_AL_BACK: begin
                link_req.pl_we    = 1'b1;
                link_req.pl_waddr = r_rid;
                link_req.pl_wdata = pida_pkg::NIL_LINK;
                n_state           = S_RESP;
            end
            S_FR_UNLINK: begin
                if (!prev_q[pida_pkg::LINK_W-1]) begin
                    link_req.nl_we    = 1'b1;
                    link_req.nl_waddr = prev_q[pida_pkg::ID_W-1:0];
                    link_req.nl_wdata = next_q;
                end else begin
                    n_head = next_q;
                end
                if (!next_q[pida_pkg::LINK_W-1]) begin
                    link_req.pl_we    = 1'b1;
                    link_req.pl_waddr = next_q[pida_pkg::ID_W-1:0];
                    link_req.pl_wdata = prev_q;
                end
                n_running[r_rid] = 1'b0;
                if (r_count != '0) begin
                    n_count = r_count - 7'd1;
                end
                if (!r_fdepth[pida_pkg::CNT_W-1]) begin
                    fs_we    = 1'b1;
                    n_fdepth = r_fdepth + 7'd1;
                end
                n_status = pida_pkg::ST_OK;
                n_rid    = '0;
                n_state  = S_RESP;
            end
            S_LIST: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = pida_pkg::ST_OK;
                    out_id     = r_rid;
                    out_last   = list_fin;
                    n_k        = k_p1;
                    n_rid      = next_q[pida_pkg::ID_W-1:0];
                    if (list_fin) begin
                        n_state = S_IDLE;
                    end else begin
                        link_req.rd_en = 1'b1;
                        link_req.raddr = next_q[pida_pkg::ID_W-1:0];
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fresh     <= '0;
            r_fdepth    <= '0;
            r_count     <= '0;
            r_head      <= pida_pkg::NIL_LINK;
            r_running   <= '0;
            r_pop       <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fresh     <= n_fresh;
            r_fdepth    <= n_fdepth;
            r_count     <= n_count;
            r_head      <= n_head;
            r_running   <= n_running;
            r_pop       <= n_pop;
            r_k         <= n_k;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rid    <= n_rid;
        r_status <= n_status;
        if (out_load) begin
            r_o_status <= out_status;
            r_o_id     <= out_id;
            r_o_total  <= r_count;
            r_o_last   <= out_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_id_out        = r_o_id;
    assign o_running_total = r_o_total;
    assign o_last          = r_o_last;

endmodule

[rtl/core/pida_checker.sv]
// Port-level checks of the process ID allocator and their bind.
module pida_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  o_status,
    input  logic [5:0]  o_id_out,
    input  logic [6:0]  o_running_total,
    input  logic        o_last
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("command beat taken while previous one still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
            && $stable(o_id_out) && $stable(o_running_total) && $stable(o_last)))
        else $error("stalled result beat changed");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != pida_pkg::ST_OK)) |-> (o_last && (o_id_out == 6'd0)))
        else $error("error result not a lone beat with zero id");

    a_list_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> ((o_status == pida_pkg::ST_OK)
            && (o_running_total >= 7'd2)))
        else $error("non-final list beat with fewer than two running ids");

endmodule

bind process_id_allocator_top pida_checker u_pida_checker (.*);
